@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the top RTL file of the image slot upload block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/isuc_pkg.sv @@
// ----------------------------------------------------------------------------
// isuc_pkg
// Types, constants and helper functions of the image slot upload controller.
// ----------------------------------------------------------------------------
`default_nettype none

package isuc_pkg;

    localparam int IMAGE_BYTES = 512;
    localparam int SLOT_COUNT  = 2;
    localparam int STORE_SIZE  = SLOT_COUNT * IMAGE_BYTES;

    localparam int IDX_W   = $clog2(IMAGE_BYTES);
    localparam int ADDR_W  = $clog2(STORE_SIZE);
    localparam int BYTES_W = $clog2(IMAGE_BYTES + 1);
    localparam int CHUNK_W = 7;
    localparam int SUM_W   = ((BYTES_W > CHUNK_W) ? BYTES_W : CHUNK_W) + 1;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef enum logic [2:0] {
        OP_BEGIN  = 3'd0,
        OP_HEADER = 3'd1,
        OP_HEX    = 3'd2,
        OP_END    = 3'd3,
        OP_TEST   = 3'd4,
        OP_CLEAR  = 3'd5,
        OP_OTHER  = 3'd6
    } op_t;

    typedef enum logic [3:0] {
        ST_READY     = 4'd0,
        ST_OK        = 4'd1,
        ST_MALFORMED = 4'd2,
        ST_RANGE     = 4'd3,
        ST_BUSY      = 4'd4,
        ST_NOT_READY = 4'd5,
        ST_BAD_HEX   = 4'd6,
        ST_CRC       = 4'd7,
        ST_UNKNOWN   = 4'd8
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;      // execute the item on the command port this cycle
        logic crc_run;   // read one stored byte into the CRC pipeline
        logic crc_done;  // CRC is final: compare and post the result
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic end_go;    // an end command now would start the CRC pass
        logic rd_last;   // the read index is at the last byte of the slot
        logic rsp_hold;  // a result is waiting and the receiver stalls
    } dp_status_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok  = 1'b1;
        d.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            d.val = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    // Reflected CRC-32 over one byte, bit by bit.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/isuc_ctrl.sv @@
// ----------------------------------------------------------------------------
// isuc_ctrl
// Sequencer: accepts command items and walks the CRC pass of an end command.
// ----------------------------------------------------------------------------
`default_nettype none

module isuc_ctrl
    import isuc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  wire logic [2:0] op,
    input  wire dp_status_t dp_status,
    output logic            cmd_stall,
    output ctrl_cmd_t       ctrl_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CRC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_CMP   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept    = (state_reg == S_IDLE) && cmd_valid && !dp_status.rsp_hold;
    assign cmd_stall = (state_reg != S_IDLE) || dp_status.rsp_hold;

    always_comb
    begin
        state_next        = state_reg;
        ctrl_cmd.exec     = 1'b0;
        ctrl_cmd.crc_run  = 1'b0;
        ctrl_cmd.crc_done = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctrl_cmd.exec = accept;
                if (accept && op == OP_END && dp_status.end_go) begin
                    state_next = S_CRC;
                end
            end
            S_CRC:
            begin
                ctrl_cmd.crc_run = 1'b1;
                if (dp_status.rd_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // The last byte is folded into the CRC at this edge.
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!dp_status.rsp_hold) begin
                    ctrl_cmd.crc_done = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/isuc_datapath.sv @@
// ----------------------------------------------------------------------------
// isuc_datapath
// Upload state, slot image memory, CRC engine and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module isuc_datapath
    import isuc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctrl_cmd_t   ctrl_cmd,
    input  wire logic [2:0]  op,
    input  wire logic [7:0]  slot,
    input  wire logic [7:0]  hex_len,
    input  wire logic [7:0]  hi_char,
    input  wire logic [7:0]  lo_char,
    input  wire logic [31:0] expected_crc,
    input  wire logic        rsp_stall,
    output dp_status_t       dp_status,
    output logic             rsp_valid,
    output logic [3:0]       status,
    output logic             display_request,
    output logic             display_slot
);

    // Upload state.
    logic               active_reg, active_next;
    logic               up_slot_reg, up_slot_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [CHUNK_W-1:0] pairs_reg, pairs_next;
    logic [CHUNK_W-1:0] offset_reg, offset_next;
    logic [1:0]         valid_reg, valid_next;

    // CRC pass.
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [7:0]         rd_data_reg;
    logic               rd_data_valid_reg;
    logic [31:0]        crc_reg;
    logic [31:0]        exp_crc_reg;

    // Result register.
    logic               rsp_valid_reg;
    status_t            status_reg;
    logic               req_reg;
    logic               dslot_reg;

    logic [7:0]         image_mem [STORE_SIZE];
    logic               mem_we;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         wr_data;

    logic               slot_ok;
    logic               sidx;
    logic [SUM_W-1:0]   hdr_sum;
    logic [SUM_W-1:0]   wr_sum;
    logic [IDX_W-1:0]   wr_idx;
    hex_digit_t         hi_d, lo_d;
    logic               crc_start;

    logic               res_valid;
    status_t            res_status;
    logic               res_req;
    logic               res_dslot;

    assign slot_ok = (slot == 8'd1) || (slot == 8'd2);
    assign sidx    = (slot == 8'd2);
    assign hi_d    = hex_decode(hi_char);
    assign lo_d    = hex_decode(lo_char);
    assign hdr_sum = SUM_W'(bytes_reg) + SUM_W'(hex_len[7:1]);
    assign wr_sum  = SUM_W'(bytes_reg) + SUM_W'(offset_reg);
    // A header that passed the bound check keeps every write inside the slot.
    assign wr_idx  = wr_sum[IDX_W-1:0];
    assign wr_addr = up_slot_reg ? ADDR_W'(IMAGE_BYTES) + ADDR_W'(wr_idx) : ADDR_W'(wr_idx);
    assign rd_addr = up_slot_reg ? ADDR_W'(IMAGE_BYTES) + ADDR_W'(rd_idx_reg)
                                 : ADDR_W'(rd_idx_reg);
    assign wr_data = {hi_d.val, lo_d.val};

    assign dp_status.end_go   = active_reg && (bytes_reg == BYTES_W'(IMAGE_BYTES));
    assign dp_status.rd_last  = (rd_idx_reg == IDX_W'(IMAGE_BYTES - 1));
    assign dp_status.rsp_hold = rsp_valid_reg && rsp_stall;

    always_comb
    begin
        active_next  = active_reg;
        up_slot_next = up_slot_reg;
        bytes_next   = bytes_reg;
        pairs_next   = pairs_reg;
        offset_next  = offset_reg;
        valid_next   = valid_reg;
        mem_we       = 1'b0;
        crc_start    = 1'b0;
        res_valid    = 1'b0;
        res_status   = ST_OK;
        res_req      = 1'b0;
        res_dslot    = 1'b0;

        if (ctrl_cmd.exec) begin
            // Any command but a hex pair drops a pending chunk.
            if (op != OP_HEX) begin
                pairs_next  = '0;
                offset_next = '0;
            end
            res_valid = 1'b1;
            case (op)
                OP_BEGIN:
                begin
                    if (!slot_ok) begin
                        res_status = ST_RANGE;
                    end else if (active_reg) begin
                        res_status = ST_BUSY;
                    end else begin
                        active_next  = 1'b1;
                        up_slot_next = sidx;
                        bytes_next   = '0;
                        res_status   = ST_READY;
                    end
                end
                OP_HEADER:
                begin
                    if (!active_reg) begin
                        res_status = ST_NOT_READY;
                    end else if (hex_len == 8'd0 || hex_len[0]) begin
                        res_status = ST_MALFORMED;
                    end else if (hdr_sum > SUM_W'(IMAGE_BYTES)) begin
                        active_next = 1'b0;
                        res_status  = ST_RANGE;
                    end else begin
                        pairs_next = hex_len[7:1];
                        res_valid  = 1'b0;
                    end
                end
                OP_HEX:
                begin
                    if (!active_reg || pairs_reg == '0) begin
                        res_status = ST_NOT_READY;
                    end else if (!hi_d.ok || !lo_d.ok) begin
                        active_next = 1'b0;
                        pairs_next  = '0;
                        offset_next = '0;
                        res_status  = ST_BAD_HEX;
                    end else begin
                        mem_we      = 1'b1;
                        offset_next = offset_reg + CHUNK_W'(1);
                        pairs_next  = pairs_reg - CHUNK_W'(1);
                        if (pairs_reg == CHUNK_W'(1)) begin
                            // Last pair of the chunk commits its bytes.
                            bytes_next  = BYTES_W'(wr_sum + SUM_W'(1));
                            offset_next = '0;
                            res_status  = ST_OK;
                        end else begin
                            res_valid = 1'b0;
                        end
                    end
                end
                OP_END:
                begin
                    if (!active_reg) begin
                        res_status = ST_NOT_READY;
                    end else if (bytes_reg != BYTES_W'(IMAGE_BYTES)) begin
                        active_next = 1'b0;
                        res_status  = ST_RANGE;
                    end else begin
                        active_next = 1'b0;
                        crc_start   = 1'b1;
                        res_valid   = 1'b0;
                    end
                end
                OP_TEST:
                begin
                    if (!slot_ok) begin
                        res_status = ST_RANGE;
                    end else if (!valid_reg[sidx]) begin
                        res_status = ST_UNKNOWN;
                    end else begin
                        res_req   = 1'b1;
                        res_dslot = sidx;
                    end
                end
                OP_CLEAR:
                begin
                    if (!slot_ok) begin
                        res_status = ST_RANGE;
                    end else begin
                        valid_next[sidx] = 1'b0;
                        active_next      = 1'b0;
                    end
                end
                default:
                begin
                    res_status = ST_UNKNOWN;
                end
            endcase
        end else if (ctrl_cmd.crc_done) begin
            res_valid = 1'b1;
            if (~crc_reg == exp_crc_reg) begin
                valid_next[up_slot_reg] = 1'b1;
            end else begin
                res_status = ST_CRC;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg        <= 1'b0;
            up_slot_reg       <= 1'b0;
            bytes_reg         <= '0;
            pairs_reg         <= '0;
            offset_reg        <= '0;
            valid_reg         <= '0;
            rd_idx_reg        <= '0;
            rd_data_valid_reg <= 1'b0;
            crc_reg           <= CRC_INIT;
            rsp_valid_reg     <= 1'b0;
        end else begin
            active_reg        <= active_next;
            up_slot_reg       <= up_slot_next;
            bytes_reg         <= bytes_next;
            pairs_reg         <= pairs_next;
            offset_reg        <= offset_next;
            valid_reg         <= valid_next;
            rd_data_valid_reg <= ctrl_cmd.crc_run;
            if (crc_start) begin
                rd_idx_reg <= '0;
                crc_reg    <= CRC_INIT;
            end else begin
                if (ctrl_cmd.crc_run) begin
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                end
                if (rd_data_valid_reg) begin
                    crc_reg <= crc_byte(crc_reg, rd_data_reg);
                end
            end
            if (res_valid) begin
                rsp_valid_reg <= 1'b1;
            end else if (!rsp_stall) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (crc_start) begin
            exp_crc_reg <= expected_crc;
        end
        if (res_valid) begin
            status_reg <= res_status;
            req_reg    <= res_req;
            dslot_reg  <= res_dslot;
        end
    end

    // Slot image memory: one write port for hex pairs, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            image_mem[wr_addr] <= wr_data;
        end
        if (ctrl_cmd.crc_run) begin
            rd_data_reg <= image_mem[rd_addr];
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign display_request = req_reg;
    assign display_slot    = dslot_reg;

endmodule

`default_nettype wire

@@ rtl/core/image_slot_upload_controller_top.sv @@
// ----------------------------------------------------------------------------
// image_slot_upload_controller_top
// Command-driven upload of images into two slots with CRC-32 validation.
// ----------------------------------------------------------------------------
// Every command item answers with at most one item on the response channel.
// An end command that passes its byte count check reads the slot image from
// the single-read-port image memory one byte per cycle into a byte-wide
// CRC-32 engine; its result is posted before the next command is taken. The
// image memory has no reset; only bytes written by the current upload are
// ever read back.
`default_nettype none
`include "assert_macros.svh"

module image_slot_upload_controller_top
    import isuc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire logic [2:0]  op,
    input  wire logic [7:0]  slot,
    input  wire logic [7:0]  hex_len,
    input  wire logic [7:0]  hi_char,
    input  wire logic [7:0]  lo_char,
    input  wire logic [31:0] expected_crc,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [3:0]       status,
    output logic             display_request,
    output logic             display_slot
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    isuc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .op        (op),
        .dp_status (dp_status),
        .cmd_stall (cmd_stall),
        .ctrl_cmd  (ctrl_cmd)
    );

    isuc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl_cmd        (ctrl_cmd),
        .op              (op),
        .slot            (slot),
        .hex_len         (hex_len),
        .hi_char         (hi_char),
        .lo_char         (lo_char),
        .expected_crc    (expected_crc),
        .rsp_stall       (rsp_stall),
        .dp_status       (dp_status),
        .rsp_valid       (rsp_valid),
        .status          (status),
        .display_request (display_request),
        .display_slot    (display_slot)
    );

    // A waiting result is never overwritten by a new command or the CRC verdict.
    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, dp_status.rsp_hold,
        !ctrl_cmd.exec && !ctrl_cmd.crc_done)
    // The CRC read pass never overlaps command execution.
    `ASSERT_IMPLIES(a_crc_exclusive, clk, rst_n, ctrl_cmd.crc_run,
        cmd_stall && !ctrl_cmd.exec)
    // A display request only comes with an ok status.
    `ASSERT_IMPLIES(a_display_ok, clk, rst_n, rsp_valid && display_request,
        status == ST_OK)
    // Once the last byte is read, the pass stops issuing reads.
    `ASSERT_NEXT(a_crc_stops, clk, rst_n, ctrl_cmd.crc_run && dp_status.rd_last,
        !ctrl_cmd.crc_run)

endmodule

`default_nettype wire

@@ bench/isuc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isuc_checker
// Watches the command and response channels of the image slot upload
// controller. It keeps its own copy of the upload state, the slot images and
// the valid marks, works out the answer to every accepted command item and
// compares each response item field by field with the oldest answer due.
// ----------------------------------------------------------------------------
module isuc_checker
    import isuc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_stall,
    input  logic [2:0]  op,
    input  logic [7:0]  slot,
    input  logic [7:0]  hex_len,
    input  logic [7:0]  hi_char,
    input  logic [7:0]  lo_char,
    input  logic [31:0] expected_crc,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [3:0]  status,
    input  logic        display_request,
    input  logic        display_slot,
    output int          errors,
    output int          pending
);

    typedef struct {
        status_t st;
        logic    show;
        logic    show_slot;
    } answer_t;

    answer_t answers_due[$];

    logic                  uploading  = 1'b0;
    logic                  target     = 1'b0;
    int                    bytes_in   = 0;
    int                    pairs_left = 0;
    int                    chunk_pos  = 0;
    logic [SLOT_COUNT-1:0] slot_good  = '0;
    logic [7:0]            image [STORE_SIZE];

    function automatic int nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    // Reflected CRC-32 over the whole image of one slot, with final inversion.
    function automatic logic [31:0] image_crc(input logic which);
        logic [31:0] acc;
        acc = CRC_INIT;
        for (int i = 0; i < IMAGE_BYTES; i++) begin
            acc ^= {24'd0, image[int'(which) * IMAGE_BYTES + i]};
            for (int b = 0; b < 8; b++)
                acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : 32'd0);
        end
        return ~acc;
    endfunction

    // Updates the upload state for one command item. Returns 1 when the item
    // is answered, with the answer in ans.
    function automatic bit command_answer(input logic [2:0] code, input logic [7:0] sl,
                                          input logic [7:0] len, input logic [7:0] hc,
                                          input logic [7:0] lc, input logic [31:0] crc_in,
                                          output answer_t ans);
        logic in_range;
        logic idx;
        int   h;
        int   l;
        in_range = (sl == 8'd1) || (sl == 8'd2);
        idx      = (sl == 8'd2);
        ans      = '{ST_OK, 1'b0, 1'b0};
        // Anything but a hex pair drops a pending chunk.
        if (code != OP_HEX) begin
            pairs_left = 0;
            chunk_pos  = 0;
        end
        case (code)
            OP_BEGIN:
            begin
                if (!in_range)
                    ans.st = ST_RANGE;
                else if (uploading)
                    ans.st = ST_BUSY;
                else
                begin
                    uploading = 1'b1;
                    target    = idx;
                    bytes_in  = 0;
                    ans.st    = ST_READY;
                end
            end
            OP_HEADER:
            begin
                if (!uploading)
                    ans.st = ST_NOT_READY;
                else if (len == 8'd0 || len[0])
                    ans.st = ST_MALFORMED;
                else if (bytes_in + (int'(len) >> 1) > IMAGE_BYTES)
                begin
                    uploading = 1'b0;
                    ans.st    = ST_RANGE;
                end
                else
                begin
                    pairs_left = int'(len) >> 1;
                    chunk_pos  = 0;
                    return 1'b0;
                end
            end
            OP_HEX:
            begin
                if (!uploading || pairs_left == 0)
                begin
                    ans.st = ST_NOT_READY;
                    return 1'b1;
                end
                h = nibble(hc);
                l = nibble(lc);
                if (h < 0 || l < 0)
                begin
                    uploading  = 1'b0;
                    pairs_left = 0;
                    chunk_pos  = 0;
                    ans.st     = ST_BAD_HEX;
                    return 1'b1;
                end
                image[int'(target) * IMAGE_BYTES + bytes_in + chunk_pos] = 8'(h * 16 + l);
                chunk_pos++;
                pairs_left--;
                if (pairs_left != 0)
                    return 1'b0;
                bytes_in  += chunk_pos;
                chunk_pos  = 0;
                ans.st     = ST_OK;
            end
            OP_END:
            begin
                if (!uploading)
                    ans.st = ST_NOT_READY;
                else
                begin
                    uploading = 1'b0;
                    if (bytes_in != IMAGE_BYTES)
                        ans.st = ST_RANGE;
                    else if (image_crc(target) != crc_in)
                        ans.st = ST_CRC;
                    else
                    begin
                        slot_good[target] = 1'b1;
                        ans.st            = ST_OK;
                    end
                end
            end
            OP_TEST:
            begin
                if (!in_range)
                    ans.st = ST_RANGE;
                else if (!slot_good[idx])
                    ans.st = ST_UNKNOWN;
                else
                    ans = '{ST_OK, 1'b1, idx};
            end
            OP_CLEAR:
            begin
                if (!in_range)
                    ans.st = ST_RANGE;
                else
                begin
                    slot_good[idx] = 1'b0;
                    uploading      = 1'b0;
                end
            end
            default:
                ans.st = ST_UNKNOWN;
        endcase
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : watch
        answer_t fresh;
        answer_t due;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                if (command_answer(op, slot, hex_len, hi_char, lo_char, expected_crc, fresh))
                    answers_due.push_back(fresh);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result item with no answer due: status %0d", status);
                    errors++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (status !== due.st)
                    begin
                        $error("status: expected %0d, got %0d", due.st, status);
                        errors++;
                    end
                    if (display_request !== due.show)
                    begin
                        $error("display_request: expected %0d, got %0d",
                               due.show, display_request);
                        errors++;
                    end
                    if (display_slot !== due.show_slot)
                    begin
                        $error("display_slot: expected %0d, got %0d",
                               due.show_slot, display_slot);
                        errors++;
                    end
                end
            end
        end
        pending = answers_due.size();
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Command stimulus for the image slot upload controller. A short directed
// sequence walks the error answers, then random traffic mixes full 512-byte
// uploads (good and bad CRC) with broken uploads and random commands, under
// random idling on both channels. The checker beside the block predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import isuc_pkg::*;

    localparam int         ITEM_TARGET  = 1170;
    localparam int         QUIET_FROM   = 1050;
    localparam int         LONG_HOLD    = 300;
    localparam int         SETTLE       = IMAGE_BYTES + 64;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam logic [2:0] OP_SPARE     = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [2:0]  op;
    logic [7:0]  slot;
    logic [7:0]  hex_len;
    logic [7:0]  hi_char;
    logic [7:0]  lo_char;
    logic [31:0] expected_crc;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [3:0]  status;
    logic        display_request;
    logic        display_slot;

    int errors;
    int pending;
    int items_sent    = 0;
    int cycles        = 0;
    int uploads       = 0;
    int last_full     = 0;
    bit calm          = 1'b0;
    bit quiet_tail    = 1'b0;
    bit hold_request  = 1'b0;

    always #4 clk = ~clk;

    image_slot_upload_controller_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .op              (op),
        .slot            (slot),
        .hex_len         (hex_len),
        .hi_char         (hi_char),
        .lo_char         (lo_char),
        .expected_crc    (expected_crc),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .display_request (display_request),
        .display_slot    (display_slot)
    );

    isuc_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .op              (op),
        .slot            (slot),
        .hex_len         (hex_len),
        .hi_char         (hi_char),
        .lo_char         (lo_char),
        .expected_crc    (expected_crc),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .display_request (display_request),
        .display_slot    (display_slot),
        .errors          (errors),
        .pending         (pending)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] rand8();
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic upper;
        upper = $urandom_range(0, 1);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    // Characters that are not hex digits, mostly just outside the digit ranges.
    function automatic logic [7:0] junk_char();
        case ($urandom_range(0, 7))
            0: return 8'h2F;
            1: return 8'h3A;
            2: return 8'h40;
            3: return 8'h47;
            4: return 8'h60;
            5: return 8'h67;
            6: return 8'h00;
            default: return 8'h80 | rand8();
        endcase
    endfunction

    function automatic logic [31:0] crc_add(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        return c;
    endfunction

    task automatic issue(input logic [2:0] code, input logic [7:0] sl, input logic [7:0] len,
                         input logic [7:0] hc, input logic [7:0] lc, input logic [31:0] crc);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        cmd_valid    <= 1'b1;
        op           <= code;
        slot         <= sl;
        hex_len      <= len;
        hi_char      <= hc;
        lo_char      <= lc;
        expected_crc <= crc;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        issue(OP_HEX, rand8(), rand8(), hex_char(b[7:4]), hex_char(b[3:0]), $urandom);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic noise_cmd();
        logic [7:0] sl;
        logic [7:0] len;
        logic [7:0] hc;
        logic [7:0] lc;
        sl  = $urandom_range(0, 1) ? 8'($urandom_range(1, 2)) : rand8();
        len = $urandom_range(0, 1) ? 8'(2 * $urandom_range(0, 8)) : rand8();
        hc  = $urandom_range(0, 1) ? hex_char(4'($urandom)) : rand8();
        lc  = $urandom_range(0, 1) ? hex_char(4'($urandom)) : rand8();
        issue(3'($urandom_range(0, 7)), sl, len, hc, lc, $urandom);
    endtask

    // A complete upload of one slot. An end up front closes any upload left
    // open by earlier traffic. Now and then the last header overshoots the
    // image end, which aborts the upload.
    task automatic full_upload(input logic which, input bit good);
        logic [31:0] acc;
        logic [31:0] crc;
        logic [7:0]  b;
        int          done;
        int          n;
        int          left;
        acc  = CRC_INIT;
        done = 0;
        issue(OP_END, rand8(), rand8(), rand8(), rand8(), $urandom);
        issue(OP_BEGIN, which ? 8'd2 : 8'd1, rand8(), rand8(), rand8(), $urandom);
        while (done < IMAGE_BYTES)
        begin
            calm = quiet_tail || ($urandom_range(0, 3) == 0);
            left = IMAGE_BYTES - done;
            if (left < 127 && $urandom_range(0, 7) == 0)
            begin
                issue(OP_HEADER, rand8(), 8'(2 * $urandom_range(left + 1, 127)),
                      rand8(), rand8(), $urandom);
                issue(OP_END, rand8(), rand8(), rand8(), rand8(), $urandom);
                return;
            end
            if ($urandom_range(0, 9) == 0)
                issue(OP_HEADER, rand8(), 8'(2 * $urandom_range(0, 127) + 1),
                      rand8(), rand8(), $urandom);
            n = $urandom_range(1, (left < 127) ? left : 127);
            issue(OP_HEADER, rand8(), 8'(2 * n), rand8(), rand8(), $urandom);
            repeat (n)
            begin
                b   = rand8();
                acc = crc_add(acc, b);
                send_byte(b);
            end
            done += n;
        end
        crc = ~acc;
        if (!good)
            crc ^= 32'd1 << $urandom_range(0, 31);
        issue(OP_END, rand8(), rand8(), rand8(), rand8(), crc);
        issue(OP_TEST, which ? 8'd2 : 8'd1, rand8(), rand8(), rand8(), $urandom);
    endtask

    // A short upload that is cut off by bad digits, stray commands or an
    // early end.
    task automatic broken_upload();
        int n;
        issue(OP_BEGIN, 8'($urandom_range(1, 2)), rand8(), rand8(), rand8(), $urandom);
        repeat ($urandom_range(1, 3))
        begin
            n = $urandom_range(1, 8);
            issue(OP_HEADER, rand8(), 8'(2 * n), rand8(), rand8(), $urandom);
            repeat (n)
            begin
                case ($urandom_range(0, 19))
                    0: issue(OP_HEX, rand8(), rand8(), junk_char(), hex_char(4'($urandom)),
                             $urandom);
                    1: issue(OP_HEX, rand8(), rand8(), hex_char(4'($urandom)), junk_char(),
                             $urandom);
                    2: noise_cmd();
                    default: send_byte(rand8());
                endcase
            end
        end
        if ($urandom_range(0, 1))
            issue(OP_END, rand8(), rand8(), rand8(), rand8(), $urandom);
        else
            noise_cmd();
    endtask

    initial
    begin : receiver
        rsp_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        op           = OP_BEGIN;
        slot         = 8'd0;
        hex_len      = 8'd0;
        hi_char      = 8'd0;
        lo_char      = 8'd0;
        expected_crc = 32'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(OP_OTHER, rand8(), rand8(), rand8(), rand8(), $urandom);
        issue(OP_SPARE, rand8(), rand8(), rand8(), rand8(), $urandom);
        issue(OP_TEST, 8'd1, rand8(), rand8(), rand8(), $urandom);
        issue(OP_TEST, 8'd0, rand8(), rand8(), rand8(), $urandom);
        issue(OP_CLEAR, 8'd255, rand8(), rand8(), rand8(), $urandom);
        issue(OP_HEADER, rand8(), 8'd2, rand8(), rand8(), $urandom);
        issue(OP_HEX, rand8(), rand8(), 8'h30, 8'h30, $urandom);
        issue(OP_END, rand8(), rand8(), rand8(), rand8(), 32'hFFFF_FFFF);
        issue(OP_CLEAR, 8'd2, rand8(), rand8(), rand8(), $urandom);
        issue(OP_BEGIN, 8'd3, rand8(), rand8(), rand8(), $urandom);
        issue(OP_BEGIN, 8'd1, rand8(), rand8(), rand8(), $urandom);
        issue(OP_BEGIN, 8'd2, rand8(), rand8(), rand8(), $urandom);
        issue(OP_HEADER, rand8(), 8'd0, rand8(), rand8(), $urandom);
        issue(OP_HEADER, rand8(), 8'd255, rand8(), rand8(), $urandom);
        issue(OP_HEX, rand8(), rand8(), 8'h41, 8'h42, $urandom);
        // The largest chunk, cut off after two pairs by a test command.
        issue(OP_HEADER, rand8(), 8'd254, rand8(), rand8(), $urandom);
        send_byte(8'h0F);
        send_byte(8'hA9);
        issue(OP_TEST, 8'd2, rand8(), rand8(), rand8(), $urandom);
        issue(OP_HEX, rand8(), rand8(), 8'h66, 8'h39, $urandom);
        issue(OP_HEADER, rand8(), 8'd4, rand8(), rand8(), $urandom);
        issue(OP_HEX, rand8(), rand8(), 8'h66, 8'h39, $urandom);
        issue(OP_HEX, rand8(), rand8(), 8'h41, 8'h30, $urandom);
        issue(OP_HEADER, rand8(), 8'd2, rand8(), rand8(), $urandom);
        issue(OP_HEX, rand8(), rand8(), 8'h67, 8'h30, $urandom);
        issue(OP_BEGIN, 8'd2, rand8(), rand8(), rand8(), $urandom);
        issue(OP_HEADER, rand8(), 8'd2, rand8(), rand8(), $urandom);
        send_byte(8'hFF);
        issue(OP_END, rand8(), rand8(), rand8(), rand8(), 32'd0);
        drain();

        // The receiver holds off while commands keep coming, so the block
        // backs up and stalls the command channel.
        hold_request = 1'b1;
        calm         = 1'b1;
        repeat (40) noise_cmd();
        calm = 1'b0;
        drain();

        while (items_sent < ITEM_TARGET)
        begin
            quiet_tail = (items_sent >= QUIET_FROM);
            calm       = quiet_tail || ($urandom_range(0, 3) == 0);
            if (items_sent - last_full > 300 || $urandom_range(0, 19) == 0)
            begin
                full_upload($urandom_range(0, 1),
                            uploads == 0 || (uploads > 1 && $urandom_range(0, 3) != 0));
                uploads++;
                last_full = items_sent;
            end
            else if ($urandom_range(0, 1))
                broken_upload();
            else
                repeat ($urandom_range(1, 12)) noise_cmd();
            if (!quiet_tail && $urandom_range(0, 7) == 0)
                drain();
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
